// ===== design/bhsa_pkg.sv =====
`default_nettype none
package bhsa_pkg;

  localparam int WordsPerPoolDef = 32;
  localparam int NumPoolsDef = 4;

  localparam int WordBits = 32;
  localparam int WordIdxW = 5;
  localparam int BitIdxW = 5;
  localparam int SlotW = 10;
  localparam int CountW = 11;
  localparam int PoolWordsW = 6;

  localparam logic [WordBits-1:0] FullWord = 32'hffff_ffff;
  localparam logic [PoolWordsW-1:0] PoolWordsReset = 6'd31;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC_WR,
    S_EVAL,
    S_DONE
  } state_t;

  function automatic logic [BitIdxW-1:0] lowest_clear(input logic [WordBits-1:0] v);
    logic [BitIdxW-1:0] b;
    b = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!v[i]) b = BitIdxW'(i);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== design/bitmap_handle_slot_allocator_core.sv =====
// Flow: free and query read the addressed bitmap word, evaluate it (free clears a set bit) and
// present the result; allocate scans from the pool's hint until a word has room, else reports full.
// Throughput: one request at a time; the allocate scan reads one bitmap word per cycle
// through the single memory read port.
// Reset: hints and counts clear at once; the bitmap memory is then swept to zero across all
// NUM_POOLS * WORDS_PER_POOL words, during which no request is taken.
`default_nettype none
module bitmap_handle_slot_allocator_core #(
  parameter int WORDS_PER_POOL = bhsa_pkg::WordsPerPoolDef,
  parameter int NUM_POOLS = bhsa_pkg::NumPoolsDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bhsa_pkg::PoolWordsW-1:0]   cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        opcode,
  input  wire logic [1:0]                        pool,
  input  wire logic [bhsa_pkg::SlotW-1:0]        slot_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bhsa_pkg::SlotW-1:0]             slot_out,
  output logic [1:0]                             status,
  output logic                                   occupied,
  output logic                                   weak_res,
  output logic [bhsa_pkg::CountW-1:0]            used_count
);

  localparam int DEPTH = NUM_POOLS * WORDS_PER_POOL;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int LIM = (WORDS_PER_POOL < 32) ? WORDS_PER_POOL : 32;

  localparam int WB = bhsa_pkg::WordBits;
  localparam int WIW = bhsa_pkg::WordIdxW;
  localparam int BIW = bhsa_pkg::BitIdxW;
  localparam int CW = bhsa_pkg::CountW;
  localparam int PWW = bhsa_pkg::PoolWordsW;

  bhsa_pkg::state_t state, state_next;

  logic [PWW-1:0] pool_words;
  logic [PWW-1:0] words;

  logic [WIW-1:0] hint  [NUM_POOLS];
  logic [CW-1:0]  count [NUM_POOLS];

  logic [1:0]               op_q;
  logic [1:0]               pool_q;
  logic [PW-1:0]            psel_q;
  logic [bhsa_pkg::SlotW-1:0] slot_q;

  logic [WIW-1:0] ptr;
  logic [PWW-1:0] iss;
  logic           chk_valid;
  logic           chk_last;
  logic [WIW-1:0] chk_word;
  logic [WIW-1:0] hit_word;
  logic [WB-1:0]  hit_data;

  logic [bhsa_pkg::SlotW-1:0] res_slot;
  logic [1:0]                 res_status;
  logic                       res_occ;
  logic [CW-1:0]              res_used;

  logic           mem_busy;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [WB-1:0]  rd_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [WB-1:0]  wr_data;

  logic           accept;
  logic           pool_ok_in;
  logic [PW-1:0]  psel_in;
  logic           alloc_in;
  logic           range_in;
  logic           issue;
  logic           found;
  logic           full;
  logic [BIW-1:0] lc_bit;
  logic           ev_in_range;
  logic           ev_bit;
  logic           ev_clear;
  logic           out_free;

  bhsa_bitmap_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .busy   (mem_busy)
  );

  always_comb begin
    if (pool_words == '0) begin
      words = PWW'(1);
    end else if (pool_words > PWW'(LIM)) begin
      words = PWW'(LIM);
    end else begin
      words = pool_words;
    end
  end

  assign in_stall   = (state != bhsa_pkg::S_IDLE) || mem_busy;
  assign accept     = in_valid && !in_stall;
  assign pool_ok_in = 32'(pool) < 32'(NUM_POOLS);
  assign psel_in    = PW'(pool);
  assign alloc_in   = (opcode == bhsa_pkg::OP_ALLOC);
  assign range_in   = PWW'(slot_index[bhsa_pkg::SlotW-1:BIW]) < words;

  assign issue = iss < words;
  assign found = chk_valid && (rd_data != bhsa_pkg::FullWord);
  assign full  = chk_valid && chk_last && !found;

  assign lc_bit      = bhsa_pkg::lowest_clear(hit_data);
  assign ev_in_range = PWW'(slot_q[bhsa_pkg::SlotW-1:BIW]) < words;
  assign ev_bit      = ev_in_range && rd_data[slot_q[BIW-1:0]];
  assign ev_clear    = ev_bit && (op_q == bhsa_pkg::OP_FREE);
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      bhsa_pkg::S_IDLE: begin
        if (accept) begin
          if (!pool_ok_in) state_next = bhsa_pkg::S_DONE;
          else if (alloc_in) state_next = bhsa_pkg::S_SCAN;
          else state_next = bhsa_pkg::S_EVAL;
        end
      end
      bhsa_pkg::S_SCAN: begin
        if (found) state_next = bhsa_pkg::S_ALLOC_WR;
        else if (full) state_next = bhsa_pkg::S_DONE;
      end
      bhsa_pkg::S_ALLOC_WR: state_next = bhsa_pkg::S_DONE;
      bhsa_pkg::S_EVAL:     state_next = bhsa_pkg::S_DONE;
      bhsa_pkg::S_DONE: begin
        if (out_free) state_next = bhsa_pkg::S_IDLE;
      end
      default: state_next = bhsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = AW'(int'(psel_q) * WORDS_PER_POOL + int'(hit_word));
    wr_data = hit_data | (WB'(1) << lc_bit);
    unique case (state)
      bhsa_pkg::S_IDLE: begin
        rd_en   = accept && pool_ok_in && !alloc_in && range_in;
        rd_addr = AW'(int'(psel_in) * WORDS_PER_POOL
                      + int'(slot_index[bhsa_pkg::SlotW-1:BIW]));
      end
      bhsa_pkg::S_SCAN: begin
        rd_en   = issue && !found;
        rd_addr = AW'(int'(psel_q) * WORDS_PER_POOL + int'(ptr));
      end
      bhsa_pkg::S_ALLOC_WR: begin
        wr_en = 1'b1;
      end
      bhsa_pkg::S_EVAL: begin
        wr_en   = ev_clear;
        wr_addr = AW'(int'(psel_q) * WORDS_PER_POOL
                      + int'(slot_q[bhsa_pkg::SlotW-1:BIW]));
        wr_data = rd_data & ~(WB'(1) << slot_q[BIW-1:0]);
      end
      bhsa_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bhsa_pkg::S_IDLE;
      pool_words <= bhsa_pkg::PoolWordsReset;
      out_valid  <= 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        hint[p]  <= '0;
        count[p] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr_en) pool_words <= cfg_wr_data;
      if (state == bhsa_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == bhsa_pkg::S_ALLOC_WR) begin
        hint[psel_q]  <= hit_word;
        count[psel_q] <= count[psel_q] + CW'(1);
      end
      if (state == bhsa_pkg::S_EVAL && ev_clear && count[psel_q] != '0) begin
        count[psel_q] <= count[psel_q] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bhsa_pkg::S_IDLE: begin
        op_q      <= opcode;
        pool_q    <= pool;
        psel_q    <= psel_in;
        slot_q    <= slot_index;
        chk_valid <= 1'b0;
        iss       <= '0;
        ptr       <= (PWW'(hint[psel_in]) < words) ? hint[psel_in] : '0;
        res_status <= bhsa_pkg::ST_BAD;
        res_occ    <= 1'b0;
        res_used   <= '0;
        res_slot   <= alloc_in ? '0 : slot_index;
      end
      bhsa_pkg::S_SCAN: begin
        if (issue) begin
          ptr <= (PWW'(ptr) == words - PWW'(1)) ? '0 : ptr + WIW'(1);
          iss <= iss + PWW'(1);
        end
        chk_valid <= issue;
        chk_last  <= (iss == words - PWW'(1));
        chk_word  <= ptr;
        if (found) begin
          hit_word <= chk_word;
          hit_data <= rd_data;
        end
        if (full) begin
          res_slot   <= '0;
          res_status <= bhsa_pkg::ST_FULL;
          res_occ    <= 1'b0;
          res_used   <= count[psel_q];
        end
      end
      bhsa_pkg::S_ALLOC_WR: begin
        res_slot   <= {hit_word, lc_bit};
        res_status <= bhsa_pkg::ST_OK;
        res_occ    <= 1'b1;
        res_used   <= count[psel_q] + CW'(1);
      end
      bhsa_pkg::S_EVAL: begin
        res_slot <= slot_q;
        if (ev_clear) begin
          res_status <= bhsa_pkg::ST_OK;
          res_occ    <= 1'b0;
          res_used   <= (count[psel_q] != '0) ? count[psel_q] - CW'(1) : '0;
        end else begin
          res_status <= ev_bit ? bhsa_pkg::ST_OK : bhsa_pkg::ST_BAD;
          res_occ    <= ev_bit;
          res_used   <= count[psel_q];
        end
      end
      bhsa_pkg::S_DONE: begin
        if (out_free) begin
          slot_out   <= res_slot;
          status     <= res_status;
          occupied   <= res_occ;
          weak_res   <= (pool_q <= 2'd1);
          used_count <= res_used;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/bhsa_bitmap_mem.sv =====
`default_nettype none
module bhsa_bitmap_mem #(
  parameter int DEPTH = bhsa_pkg::WordsPerPoolDef * bhsa_pkg::NumPoolsDef,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic [bhsa_pkg::WordBits-1:0]     rd_data,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [bhsa_pkg::WordBits-1:0] wr_data,
  output logic                              busy
);

  logic [bhsa_pkg::WordBits-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;

  logic                          we;
  logic [AW-1:0]                 wa;
  logic [bhsa_pkg::WordBits-1:0] wd;

  always_comb begin
    if (busy) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
